@@ rtl/set_assoc_writeback_lru_cache_top_macros.svh @@
// Assertion macros for the set-associative write-back LRU cache.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_MACROS_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAWLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SAWLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sawlc_pkg.sv @@
// Shared types, constants and helper functions of the LRU cache tag store.
package sawlc_pkg;

   localparam int WAYS_DEF        = 2;
   localparam int SETS_DEF        = 1024;
   localparam int BLOCK_BYTES_DEF = 32;
   localparam int ADDR_BITS_DEF   = 32;

   localparam int PENALTY_W = 10;
   localparam int CYCLES_W  = 11;
   localparam int CNT_W     = 32;
   localparam int ADDER_W   = 4;

   localparam logic [PENALTY_W-1:0] PENALTY_RST = PENALTY_W'(30);
   localparam logic [CYCLES_W-1:0]  EVICT_EXTRA = CYCLES_W'(2);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic lookup_en;
      logic commit_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_status_type;

   function automatic int floor_log2(input int v);
      int n;
      n = 0;
      for (int i = 0; i < 31; i++) begin
         if ((v >> (i + 1)) != 0) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   // Extra fill cycles charged for the line size.
   function automatic logic [ADDER_W-1:0] block_adder(input int bytes);
      logic [ADDER_W-1:0] r;
      case (bytes)
         16:      r = ADDER_W'(0);
         32:      r = ADDER_W'(2);
         64:      r = ADDER_W'(6);
         128:     r = ADDER_W'(12);
         default: r = ADDER_W'(0);
      endcase
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CYCLES_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + (CNT_W + 1)'(b);
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage

@@ rtl/sawlc_ctrl.sv @@
// Sequencer of the cache tag store: clear pass, accept, lookup and commit.
module sawlc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sawlc_pkg::dp_status_type status,
   output sawlc_pkg::ctrl_cmd_type  cmd
);

   sawlc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sawlc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sawlc_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = sawlc_pkg::ST_IDLE;
         end
         sawlc_pkg::ST_IDLE: begin
            if (req_valid) state_in = sawlc_pkg::ST_LOOKUP;
         end
         sawlc_pkg::ST_LOOKUP: begin
            if (status.out_free) state_in = sawlc_pkg::ST_IDLE;
         end
         default: state_in = sawlc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sawlc_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         sawlc_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.lookup_en = req_valid;
         end
         sawlc_pkg::ST_LOOKUP: begin
            cmd.commit_en = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/sawlc_dpath.sv @@
// Datapath of the cache tag store: set memories, way selection, LRU ranks, counters.
module sawlc_dpath #(
   parameter int WAYS        = sawlc_pkg::WAYS_DEF,
   parameter int SETS        = sawlc_pkg::SETS_DEF,
   parameter int BLOCK_BYTES = sawlc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = sawlc_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sawlc_pkg::ctrl_cmd_type              cmd,
   output sawlc_pkg::dp_status_type             status,
   input  logic                                 csr_write,
   input  logic [sawlc_pkg::PENALTY_W-1:0]      csr_base_penalty,
   input  logic [ADDR_BITS-1:0]                 req_address,
   input  logic                                 req_is_store,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic                                 rsp_way_used,
   output logic                                 rsp_dirty_eviction,
   output logic [sawlc_pkg::CYCLES_W-1:0]       rsp_cycles_added,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_load_hit_total,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_load_miss_total,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_store_hit_total,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_store_miss_total,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_eviction_total,
   output logic [sawlc_pkg::CNT_W-1:0]          rsp_stall_sum
);

   localparam int OFF_W   = sawlc_pkg::floor_log2(BLOCK_BYTES);
   localparam int IDX_W   = sawlc_pkg::floor_log2(SETS);
   localparam int SET_AW  = (IDX_W > 0) ? IDX_W : 1;
   localparam int TAG_RAW = ADDR_BITS - OFF_W - IDX_W;
   localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int META_W  = WAYS * (2 + AGE_W);
   localparam int TROW_W  = WAYS * TAG_W;
   localparam logic [sawlc_pkg::ADDER_W-1:0] ADDER = sawlc_pkg::block_adder(BLOCK_BYTES);
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

   // Per-set row: valid bits, dirty bits, then the age ranks.
   logic [META_W-1:0] meta_mem [SETS];
   logic [TROW_W-1:0] tag_mem  [SETS];

   logic [META_W-1:0] meta_rd_ff;
   logic [TROW_W-1:0] tag_rd_ff;
   logic [SET_AW-1:0] set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              store_ff;
   logic [SET_AW-1:0] clr_ptr_ff;
   logic [sawlc_pkg::PENALTY_W-1:0] penalty_ff;

   logic [SET_AW-1:0] req_set;
   logic [TAG_W-1:0]  req_tag;
   logic [ADDR_BITS-1:0] set_full;
   logic [ADDR_BITS-1:0] tag_full;

   assign set_full = (req_address >> OFF_W) & ADDR_BITS'(SETS - 1);
   assign tag_full = req_address >> (OFF_W + IDX_W);
   assign req_set  = set_full[SET_AW-1:0];
   assign req_tag  = tag_full[TAG_W-1:0];

   // Lookup and update of the set row
   logic [WAYS-1:0]  line_v, line_d, new_v, new_d;
   logic [AGE_W-1:0] line_a [WAYS];
   logic [AGE_W-1:0] new_a  [WAYS];
   logic [TAG_W-1:0] line_t [WAYS];
   logic [TAG_W-1:0] new_t  [WAYS];
   logic             hit_c, inv_found;
   logic [WAY_W-1:0] hit_way, inv_way, lru_way, way_sel;
   logic [AGE_W-1:0] best_age, age_ref;
   logic             dirty_ev;
   logic [META_W-1:0] meta_wr;
   logic [TROW_W-1:0] tag_wr;
   logic [sawlc_pkg::CYCLES_W-1:0] cycles_c;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         line_v[w] = meta_rd_ff[w];
         line_d[w] = meta_rd_ff[WAYS + w];
         line_a[w] = meta_rd_ff[2 * WAYS + w * AGE_W +: AGE_W];
         line_t[w] = tag_rd_ff[w * TAG_W +: TAG_W];
      end

      hit_c   = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_c && line_v[w] && (line_t[w] == tag_ff)) begin
            hit_c   = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!inv_found && !line_v[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end

      // Oldest rank, lowest way on a tie
      best_age = '0;
      lru_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (line_a[w] > best_age) begin
            best_age = line_a[w];
            lru_way  = WAY_W'(w);
         end
      end

      way_sel  = hit_c ? hit_way : (inv_found ? inv_way : lru_way);
      dirty_ev = !hit_c && line_v[way_sel] && line_d[way_sel];
      age_ref  = line_v[way_sel] ? line_a[way_sel] : AGE_OLDEST;

      for (int k = 0; k < WAYS; k++) begin
         new_v[k] = line_v[k];
         new_d[k] = line_d[k];
         new_t[k] = line_t[k];
         new_a[k] = line_a[k];
         if (WAY_W'(k) == way_sel) begin
            new_a[k] = '0;
            if (hit_c) begin
               new_d[k] = line_d[k] | store_ff;
            end else begin
               new_v[k] = 1'b1;
               new_d[k] = store_ff;
               new_t[k] = tag_ff;
            end
         end else if (line_v[k] && (line_a[k] < age_ref)) begin
            new_a[k] = line_a[k] + 1'b1;
         end
      end

      for (int w = 0; w < WAYS; w++) begin
         meta_wr[w]                            = new_v[w];
         meta_wr[WAYS + w]                     = new_d[w];
         meta_wr[2 * WAYS + w * AGE_W +: AGE_W] = new_a[w];
         tag_wr[w * TAG_W +: TAG_W]            = new_t[w];
      end

      if (hit_c) begin
         cycles_c = '0;
      end else begin
         cycles_c = sawlc_pkg::CYCLES_W'(penalty_ff) + sawlc_pkg::CYCLES_W'(ADDER)
                    + (dirty_ev ? sawlc_pkg::EVICT_EXTRA : '0);
      end
   end

   // Set memories: one write and one registered read per cycle
   logic              meta_we;
   logic [SET_AW-1:0] meta_wa;
   logic [META_W-1:0] meta_wd;

   assign meta_we = cmd.clear_en | cmd.commit_en;
   assign meta_wa = cmd.clear_en ? clr_ptr_ff : set_ff;
   assign meta_wd = cmd.clear_en ? '0 : meta_wr;

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (cmd.lookup_en) meta_rd_ff <= meta_mem[req_set];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_en) tag_mem[set_ff] <= tag_wr;
      if (cmd.lookup_en) tag_rd_ff <= tag_mem[req_set];
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_en) begin
         set_ff   <= req_set;
         tag_ff   <= req_tag;
         store_ff <= req_is_store;
      end
   end

   // Clear sweep pointer, penalty register
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         penalty_ff <= sawlc_pkg::PENALTY_RST;
      end else begin
         if (cmd.clear_en) clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (csr_write) penalty_ff <= csr_base_penalty;
      end
   end

   // Counters; their values are the totals of the held result
   logic [sawlc_pkg::CNT_W-1:0] ld_hit_ff, ld_miss_ff, st_hit_ff, st_miss_ff;
   logic [sawlc_pkg::CNT_W-1:0] evict_ff, stall_ff;
   logic [sawlc_pkg::CNT_W-1:0] ld_hit_in, ld_miss_in, st_hit_in, st_miss_in;
   logic [sawlc_pkg::CNT_W-1:0] evict_in, stall_in;
   localparam logic [sawlc_pkg::CYCLES_W-1:0] ONE = sawlc_pkg::CYCLES_W'(1);

   always_comb begin
      ld_hit_in  = ld_hit_ff;
      ld_miss_in = ld_miss_ff;
      st_hit_in  = st_hit_ff;
      st_miss_in = st_miss_ff;
      evict_in   = evict_ff;
      stall_in   = stall_ff;
      if (cmd.commit_en) begin
         if (hit_c && store_ff)   st_hit_in  = sawlc_pkg::sat_add(st_hit_ff, ONE);
         if (hit_c && !store_ff)  ld_hit_in  = sawlc_pkg::sat_add(ld_hit_ff, ONE);
         if (!hit_c && store_ff)  st_miss_in = sawlc_pkg::sat_add(st_miss_ff, ONE);
         if (!hit_c && !store_ff) ld_miss_in = sawlc_pkg::sat_add(ld_miss_ff, ONE);
         if (dirty_ev)            evict_in   = sawlc_pkg::sat_add(evict_ff, ONE);
         if (!hit_c)              stall_in   = sawlc_pkg::sat_add(stall_ff, cycles_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_hit_ff  <= '0;
         ld_miss_ff <= '0;
         st_hit_ff  <= '0;
         st_miss_ff <= '0;
         evict_ff   <= '0;
         stall_ff   <= '0;
      end else begin
         ld_hit_ff  <= ld_hit_in;
         ld_miss_ff <= ld_miss_in;
         st_hit_ff  <= st_hit_in;
         st_miss_ff <= st_miss_in;
         evict_ff   <= evict_in;
         stall_ff   <= stall_in;
      end
   end

   // Output word register
   logic rsp_valid_ff, rsp_hit_ff, rsp_way_ff, rsp_dirty_ff;
   logic [sawlc_pkg::CYCLES_W-1:0] rsp_cycles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_en) begin
         rsp_hit_ff    <= hit_c;
         rsp_way_ff    <= way_sel[0];
         rsp_dirty_ff  <= dirty_ev;
         rsp_cycles_ff <= cycles_c;
      end
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.clear_last = (clr_ptr_ff == SET_AW'(SETS - 1));

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_way_used         = rsp_way_ff;
   assign rsp_dirty_eviction   = rsp_dirty_ff;
   assign rsp_cycles_added     = rsp_cycles_ff;
   assign rsp_load_hit_total   = ld_hit_ff;
   assign rsp_load_miss_total  = ld_miss_ff;
   assign rsp_store_hit_total  = st_hit_ff;
   assign rsp_store_miss_total = st_miss_ff;
   assign rsp_eviction_total   = evict_ff;
   assign rsp_stall_sum        = stall_ff;

endmodule

@@ rtl/set_assoc_writeback_lru_cache_top.sv @@
// Top level of the set-associative write-back LRU cache tag store.
//
// Tag store of a write-back, write-allocate cache with true LRU replacement.
// Each request word carries a byte address and a load/store flag; each one
// gives exactly one response word with hit, the way that hit or was filled,
// a dirty-eviction flag, the stall cycles charged (the base penalty plus the
// line-size adder, plus 2 on a dirty eviction; 0 on a hit) and the running
// saturating totals after this access. In an access, the accept cycle reads
// the set row from the tag and state memories into a register; the lookup
// state then compares all ways, picks the victim, writes the updated row back
// and loads the response register. That read-modify-write of one set memory
// port is what sets the rate; one access is in flight at a time. The response
// register parts the two sides, so a new request is taken while a finished
// response waits, and a second result stalls only if the first is still
// unclaimed. After reset the valid, dirty and rank memory is swept clear one
// set per cycle, all SETS sets (1024 by default), with req_stall high. The
// base penalty register (reset 30) is written through the csr port in any
// cycle; write it only while the block is idle.

`include "set_assoc_writeback_lru_cache_top_macros.svh"

module set_assoc_writeback_lru_cache_top #(
   parameter int WAYS        = sawlc_pkg::WAYS_DEF,
   parameter int SETS        = sawlc_pkg::SETS_DEF,
   parameter int BLOCK_BYTES = sawlc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = sawlc_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sawlc_pkg::PENALTY_W-1:0]   csr_base_penalty,
   // request words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ADDR_BITS-1:0]              req_address,
   input  logic                              req_is_store,
   // response words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_way_used,
   output logic                              rsp_dirty_eviction,
   output logic [sawlc_pkg::CYCLES_W-1:0]    rsp_cycles_added,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_load_hit_total,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_load_miss_total,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_store_hit_total,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_store_miss_total,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_eviction_total,
   output logic [sawlc_pkg::CNT_W-1:0]       rsp_stall_sum
);

   sawlc_pkg::ctrl_cmd_type  cmd;
   sawlc_pkg::dp_status_type status;

   // The register is a plain flop, so a write is always taken.
   assign csr_ready = 1'b1;

   sawlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sawlc_dpath #(
      .WAYS        (WAYS),
      .SETS        (SETS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write            (csr_valid & csr_ready),
      .csr_base_penalty     (csr_base_penalty),
      .req_address          (req_address),
      .req_is_store         (req_is_store),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_way_used         (rsp_way_used),
      .rsp_dirty_eviction   (rsp_dirty_eviction),
      .rsp_cycles_added     (rsp_cycles_added),
      .rsp_load_hit_total   (rsp_load_hit_total),
      .rsp_load_miss_total  (rsp_load_miss_total),
      .rsp_store_hit_total  (rsp_store_hit_total),
      .rsp_store_miss_total (rsp_store_miss_total),
      .rsp_eviction_total   (rsp_eviction_total),
      .rsp_stall_sum        (rsp_stall_sum)
   );

   // One access in flight: the cycle after an accept is the lookup cycle.
   `SAWLC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "overlap")
   // A commit never overwrites a response still waiting to be taken.
   `SAWLC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.commit_en, !rsp_valid || !rsp_stall, "clobber")
   // Every commit shows up as a response word.
   `SAWLC_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit_en, rsp_valid, "no response")
   // No request is taken during the clear sweep.
   `SAWLC_ASSERT_NOW(a_clear_blocks, clock, reset, cmd.clear_en, req_stall && !cmd.lookup_en, "busy")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the set-associative write-back LRU cache tag store.
`timescale 1ns / 100ps

module tb_top;

   // ---------------------------------------------------------------------
   // Geometry, worked out here rather than taken from the RTL.
   // 32-byte lines, 1024 sets, 2 ways, so address = {tag[16:0], set[9:0], offset[4:0]}.
   // ---------------------------------------------------------------------
   localparam int WAYS        = sawlc_pkg::WAYS_DEF;
   localparam int SETS        = sawlc_pkg::SETS_DEF;
   localparam int BLOCK_BYTES = sawlc_pkg::BLOCK_BYTES_DEF;
   localparam int ADDR_BITS   = sawlc_pkg::ADDR_BITS_DEF;
   localparam int PENALTY_W   = sawlc_pkg::PENALTY_W;
   localparam int CYCLES_W    = sawlc_pkg::CYCLES_W;
   localparam int CNT_W       = sawlc_pkg::CNT_W;
   localparam int LINES  = WAYS * SETS;
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int IDX_W  = $clog2(SETS);
   localparam int TAG_W  = ADDR_BITS - OFF_W - IDX_W;
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_ADDER = (BLOCK_BYTES == 16)  ? 0  :
                               (BLOCK_BYTES == 32)  ? 2  :
                               (BLOCK_BYTES == 64)  ? 6  :
                               (BLOCK_BYTES == 128) ? 12 : 0;
   localparam int DIRTY_EXTRA = 2;

   localparam logic ACC_LOAD  = 1'b0;
   localparam logic ACC_STORE = 1'b1;

   localparam int N_DIRECTED  = 16;
   localparam int N_PHASES    = 5;
   localparam int PHASE_WORDS = 360;
   // Covers the post-reset clearing sweep (one set per cycle) plus the longest stalls.
   localparam int IDLE_LIMIT  = 6000;

   typedef struct packed {
      logic                hit;
      logic                way;
      logic                dirty_ev;
      logic [CYCLES_W-1:0] cycles;
      logic [CNT_W-1:0]    ld_hits;
      logic [CNT_W-1:0]    ld_misses;
      logic [CNT_W-1:0]    st_hits;
      logic [CNT_W-1:0]    st_misses;
      logic [CNT_W-1:0]    evictions;
      logic [CNT_W-1:0]    stall_total;
   } access_result_type;

   // One access; where 'typed' is set the first four result fields are given by hand.
   typedef struct packed {
      logic [31:0]         addr;
      logic                store;
      logic                typed;
      logic                hit;
      logic                way;
      logic                dirty_ev;
      logic [CYCLES_W-1:0] cycles;
   } access_row_type;

   // ---------------------------------------------------------------------
   // DUT ports
   // ---------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [PENALTY_W-1:0]      csr_base_penalty = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ADDR_BITS-1:0]      req_address = '0;
   logic                      req_is_store = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_hit;
   logic                      rsp_way_used;
   logic                      rsp_dirty_eviction;
   logic [CYCLES_W-1:0]       rsp_cycles_added;
   logic [CNT_W-1:0]          rsp_load_hit_total;
   logic [CNT_W-1:0]          rsp_load_miss_total;
   logic [CNT_W-1:0]          rsp_store_hit_total;
   logic [CNT_W-1:0]          rsp_store_miss_total;
   logic [CNT_W-1:0]          rsp_eviction_total;
   logic [CNT_W-1:0]          rsp_stall_sum;

   // ---------------------------------------------------------------------
   // Shadow tag store and counters
   // ---------------------------------------------------------------------
   bit                        way_valid [LINES];
   bit                        way_dirty [LINES];
   bit [TAG_W-1:0]            way_tag   [LINES];
   bit [RANK_W-1:0]           way_rank  [LINES];   // 0 = most recently used
   logic [PENALTY_W-1:0]      penalty_now = sawlc_pkg::PENALTY_RST;
   logic [CNT_W-1:0]          ld_hit_cnt = '0, ld_miss_cnt = '0;
   logic [CNT_W-1:0]          st_hit_cnt = '0, st_miss_cnt = '0;
   logic [CNT_W-1:0]          evict_cnt = '0, stall_cnt = '0;

   access_result_type         expected_words [$];
   access_row_type            directed_rows [N_DIRECTED];
   logic [IDX_W-1:0]          set_pool [8];
   logic [TAG_W-1:0]          tag_pool [4];
   logic [PENALTY_W-1:0]      phase_penalty [N_PHASES];

   bit                        no_idle = 1'b0;    // quiet stretch: no gaps, no stalls
   int                        stall_hold = 0;
   int                        stall_pick;
   int                        idle_cycles = 0;
   int                        mismatches = 0;
   int                        words_sent = 0, words_checked = 0;
   int                        hit_seen = 0, miss_seen = 0, dirty_seen = 0;
   int                        penalty_writes = 0;
   access_result_type         got_word, want_word;
   access_row_type            row;

   set_assoc_writeback_lru_cache_top DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_base_penalty     (csr_base_penalty),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_address          (req_address),
      .req_is_store         (req_is_store),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_way_used         (rsp_way_used),
      .rsp_dirty_eviction   (rsp_dirty_eviction),
      .rsp_cycles_added     (rsp_cycles_added),
      .rsp_load_hit_total   (rsp_load_hit_total),
      .rsp_load_miss_total  (rsp_load_miss_total),
      .rsp_store_hit_total  (rsp_store_hit_total),
      .rsp_store_miss_total (rsp_store_miss_total),
      .rsp_eviction_total   (rsp_eviction_total),
      .rsp_stall_sum        (rsp_stall_sum)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   // Make way w the youngest; valid lines younger than its old rank age by one.
   // An invalid way counts as the oldest possible rank.
   function automatic void promote_way(input int unsigned base, input int unsigned w);
      int unsigned old_rank;
      old_rank = way_valid[base + w] ? way_rank[base + w] : WAYS - 1;
      for (int unsigned k = 0; k < WAYS; k++) begin
         if (k != w && way_valid[base + k] && way_rank[base + k] < old_rank) begin
            way_rank[base + k] = way_rank[base + k] + 1'b1;
         end
      end
      way_rank[base + w] = '0;
   endfunction

   function automatic access_result_type cache_lookup(input logic [31:0] addr,
                                                      input logic store);
      int unsigned    set_no, base, victim, oldest;
      logic [TAG_W-1:0] tag;
      logic           hit, found, dirty_ev;
      logic [CYCLES_W-1:0] cost;
      access_result_type r;
      set_no   = addr[OFF_W +: IDX_W];
      tag      = addr[OFF_W + IDX_W +: TAG_W];
      base     = set_no * WAYS;
      hit      = 1'b0;
      found    = 1'b0;
      dirty_ev = 1'b0;
      victim   = 0;
      cost     = '0;
      for (int unsigned w = 0; w < WAYS; w++) begin
         if (!hit && way_valid[base + w] && way_tag[base + w] == tag) begin
            hit    = 1'b1;
            victim = w;
         end
      end
      if (hit) begin
         if (store == ACC_STORE) begin
            st_hit_cnt = bump_sat(st_hit_cnt, 1);
            way_dirty[base + victim] = 1'b1;
         end else begin
            ld_hit_cnt = bump_sat(ld_hit_cnt, 1);
         end
         promote_way(base, victim);
      end else begin
         if (store == ACC_STORE) st_miss_cnt = bump_sat(st_miss_cnt, 1);
         else                    ld_miss_cnt = bump_sat(ld_miss_cnt, 1);
         cost = CYCLES_W'(penalty_now) + CYCLES_W'(LINE_ADDER);
         // first free way, else the oldest (lowest way on a tie)
         for (int unsigned w = 0; w < WAYS; w++) begin
            if (!found && !way_valid[base + w]) begin
               victim = w;
               found  = 1'b1;
            end
         end
         if (!found) begin
            oldest = 0;
            for (int unsigned w = 0; w < WAYS; w++) begin
               if (way_rank[base + w] > oldest) begin
                  oldest = way_rank[base + w];
                  victim = w;
               end
            end
         end
         if (way_valid[base + victim] && way_dirty[base + victim]) begin
            dirty_ev  = 1'b1;
            cost      = cost + CYCLES_W'(DIRTY_EXTRA);
            evict_cnt = bump_sat(evict_cnt, 1);
         end
         stall_cnt = bump_sat(stall_cnt, CNT_W'(cost));
         promote_way(base, victim);
         way_valid[base + victim] = 1'b1;
         way_dirty[base + victim] = store;
         way_tag[base + victim]   = tag;
      end
      r.hit         = hit;
      r.way         = victim[0];
      r.dirty_ev    = dirty_ev;
      r.cycles      = cost;
      r.ld_hits     = ld_hit_cnt;
      r.ld_misses   = ld_miss_cnt;
      r.st_hits     = st_hit_cnt;
      r.st_misses   = st_miss_cnt;
      r.evictions   = evict_cnt;
      r.stall_total = stall_cnt;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Idling: mostly none, some short, a few long
   // ---------------------------------------------------------------------
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request side. Called at a rising edge; returns at the edge the word is taken,
   // where the shadow store is updated and the expected response queued.
   // ---------------------------------------------------------------------
   task automatic send_access(input access_row_type a);
      access_result_type pred;
      req_address  <= a.addr;
      req_is_store <= a.store;
      req_valid    <= 1'b1;
      do @(posedge clock); while (req_stall);
      pred = cache_lookup(a.addr, a.store);
      if (a.typed) begin
         // hand-worked values stand in for the predicted ones
         pred.hit      = a.hit;
         pred.way      = a.way;
         pred.dirty_ev = a.dirty_ev;
         pred.cycles   = a.cycles;
      end
      expected_words.push_back(pred);
      words_sent++;
      if (pred.hit) hit_seen++;
      else          miss_seen++;
      if (pred.dirty_ev) dirty_seen++;
   endtask

   task automatic gap_after_word();
      int len;
      len = idle_len();
      if (len != 0) begin
         req_valid <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   // Only with nothing in flight: drain, let the pipeline settle, then write.
   task automatic write_penalty(input logic [PENALTY_W-1:0] v);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_base_penalty <= v;
      csr_valid        <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      penalty_now = v;
      penalty_writes++;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = idle_len();
         rsp_stall  <= (stall_pick != 0);
         stall_hold <= (stall_pick != 0) ? stall_pick - 1 : $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word.hit         = rsp_hit;
         got_word.way         = rsp_way_used;
         got_word.dirty_ev    = rsp_dirty_eviction;
         got_word.cycles      = rsp_cycles_added;
         got_word.ld_hits     = rsp_load_hit_total;
         got_word.ld_misses   = rsp_load_miss_total;
         got_word.st_hits     = rsp_store_hit_total;
         got_word.st_misses   = rsp_store_miss_total;
         got_word.evictions   = rsp_eviction_total;
         got_word.stall_total = rsp_stall_sum;
         if (expected_words.size() == 0) begin
            flag_mismatch("response word with nothing outstanding");
         end else begin
            want_word = expected_words.pop_front();
            if (got_word.hit !== want_word.hit)
               flag_mismatch($sformatf("word %0d hit %0h, want %0h",
                  words_checked, got_word.hit, want_word.hit));
            if (got_word.way !== want_word.way)
               flag_mismatch($sformatf("word %0d way_used %0h, want %0h",
                  words_checked, got_word.way, want_word.way));
            if (got_word.dirty_ev !== want_word.dirty_ev)
               flag_mismatch($sformatf("word %0d dirty_eviction %0h, want %0h",
                  words_checked, got_word.dirty_ev, want_word.dirty_ev));
            if (got_word.cycles !== want_word.cycles)
               flag_mismatch($sformatf("word %0d cycles_added %0d, want %0d",
                  words_checked, got_word.cycles, want_word.cycles));
            if (got_word.ld_hits !== want_word.ld_hits)
               flag_mismatch($sformatf("word %0d load_hit_total %0d, want %0d",
                  words_checked, got_word.ld_hits, want_word.ld_hits));
            if (got_word.ld_misses !== want_word.ld_misses)
               flag_mismatch($sformatf("word %0d load_miss_total %0d, want %0d",
                  words_checked, got_word.ld_misses, want_word.ld_misses));
            if (got_word.st_hits !== want_word.st_hits)
               flag_mismatch($sformatf("word %0d store_hit_total %0d, want %0d",
                  words_checked, got_word.st_hits, want_word.st_hits));
            if (got_word.st_misses !== want_word.st_misses)
               flag_mismatch($sformatf("word %0d store_miss_total %0d, want %0d",
                  words_checked, got_word.st_misses, want_word.st_misses));
            if (got_word.evictions !== want_word.evictions)
               flag_mismatch($sformatf("word %0d eviction_total %0d, want %0d",
                  words_checked, got_word.evictions, want_word.evictions));
            if (got_word.stall_total !== want_word.stall_total)
               flag_mismatch($sformatf("word %0d stall_sum %0d, want %0d",
                  words_checked, got_word.stall_total, want_word.stall_total));
         end
         words_checked++;
      end
   end

   // Watchdog: too long without any word moving on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without progress, %0d words outstanding",
                  idle_cycles, expected_words.size());
         $display("set_assoc_writeback_lru_cache_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      // Directed accesses at the reset penalty of 30: a miss costs 32, 34 with a
      // dirty victim. Set 0 sees tags 0, 1 and 2 fight over two ways.
      directed_rows = '{
         // cold miss straight after reset fills way 0
         '{32'h0000_0000, ACC_LOAD,  1'b1, 1'b0, 1'b0, 1'b0, 11'd32},
         // store hit marks it dirty, no charge
         '{32'h0000_0000, ACC_STORE, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0},
         // top of the address space: last set, all-ones tag
         '{32'hFFFF_FFFF, ACC_LOAD,  1'b1, 1'b0, 1'b0, 1'b0, 11'd32},
         // second tag in set 0 takes the free way
         '{32'h0000_8000, ACC_STORE, 1'b1, 1'b0, 1'b1, 1'b0, 11'd32},
         // set full: way 0 is oldest and dirty, so written back
         '{32'h0001_0000, ACC_LOAD,  1'b1, 1'b0, 1'b0, 1'b1, 11'd34},
         '{32'h0000_8000, ACC_LOAD,  1'b1, 1'b1, 1'b1, 1'b0, 11'd0},
         // clean victim: no write-back charge
         '{32'h0000_0000, ACC_STORE, 1'b1, 1'b0, 1'b0, 1'b0, 11'd32},
         // way 1 still dirty from the earlier store
         '{32'h0001_0000, ACC_STORE, 1'b1, 1'b0, 1'b1, 1'b1, 11'd34},
         '{32'hFFFF_FFE0, ACC_STORE, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0},
         // offset bits all ones still land on the same line
         '{32'h0000_001F, ACC_LOAD,  1'b1, 1'b1, 1'b0, 1'b0, 11'd0},
         '{32'h7FFF_FFFF, ACC_LOAD,  1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
         '{32'h8000_0000, ACC_STORE, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
         '{32'hAAAA_AAAA, ACC_STORE, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
         '{32'h5555_5555, ACC_LOAD,  1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
         '{32'hAAAA_AAAA, ACC_LOAD,  1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
         // last set, tag 0: evicts the dirty all-ones line
         '{32'h0000_7FE0, ACC_STORE, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0}
      };
      // Phase 0 runs at the reset value; the rest cover both extremes, a random middle value and 1.
      phase_penalty = '{sawlc_pkg::PENALTY_RST, 10'd1023, 10'd0,
                        PENALTY_W'($urandom_range(1, 1022)), 10'd1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The block stalls requests while it sweeps its valid, dirty and rank memory after reset.
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_access(directed_rows[i]);
         gap_after_word();
      end

      for (int p = 0; p < N_PHASES; p++) begin
         if (p != 0) begin
            write_penalty(phase_penalty[p]);
         end
         // A handful of sets and tags per phase so lines collide: hits, LRU
         // choices and dirty write-backs all come up often.
         foreach (set_pool[i]) set_pool[i] = IDX_W'($urandom);
         foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            row = '0;
            row.store = $urandom_range(0, 1) ? ACC_STORE : ACC_LOAD;
            if ($urandom_range(0, 99) < 80) begin
               row.addr = {tag_pool[$urandom_range(0, 3)], set_pool[$urandom_range(0, 7)],
                           OFF_W'($urandom)};
            end else begin
               row.addr = $urandom;
            end
            send_access(row);
            gap_after_word();
         end
         // nothing more to offer until the next phase
         req_valid <= 1'b0;
      end
      no_idle = 1'b0;

      // Drain, then give the two-stage pipeline time to show any stray word.
      while (expected_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("%0d accesses checked: %0d hits, %0d misses, %0d dirty write-backs",
               words_checked, hit_seen, miss_seen, dirty_seen);
      $display("miss penalty rewritten %0d times, 0 and 1023 included; %0d mismatches",
               penalty_writes, mismatches);
      if (mismatches == 0) begin
         $display("set_assoc_writeback_lru_cache_top regression: pass");
      end else begin
         $display("set_assoc_writeback_lru_cache_top regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sawlc_pkg.sv
rtl/sawlc_ctrl.sv
rtl/sawlc_dpath.sv
rtl/set_assoc_writeback_lru_cache_top.sv
bench/tb_top.sv
